@@ rtl/swit_pkg.sv @@
// Package: shared types and codes for the stopwatch interval timer.
package swit_pkg;

    localparam int unsigned TIME_W = 32;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_RESET = 3'd2,
        OP_CHECK = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [0:0] {
        CFG_PERIODIC_MODE = 1'b0,
        CFG_PERIOD_MS     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              periodic_mode;
        logic [TIME_W-1:0] period_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        operation;
        logic [TIME_W-1:0] now_ms;
    } t_item;

endpackage

@@ rtl/swit_cfg.sv @@
// Configuration register file: timer mode and period.
module swit_cfg
    import swit_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [TIME_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIODIC_MODE: n_cfg.periodic_mode = i_cfg_data[0];
                CFG_PERIOD_MS:     n_cfg.period_ms     = i_cfg_data;
                default:           n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/swit_in_stage.sv @@
// Input register: holds one command beat for the timer core.
module swit_in_stage
    import swit_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_vld;
    logic  n_vld;
    t_item r_item;
    logic  load;

    assign o_stall = r_vld && !i_ready;
    assign load    = i_valid && !o_stall;
    assign n_vld   = load || (r_vld && !i_ready);
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/swit_core.sv @@
// Timer core: run state, expiry check and result register.
module swit_core
    import swit_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_item             i_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [TIME_W-1:0] o_out_elapsed_ms,
    output logic              o_out_expired,
    output logic              o_out_running
);

    logic              r_active;
    logic              n_active;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] n_start;
    logic [TIME_W-1:0] r_bt;
    logic [TIME_W-1:0] n_bt;
    logic [TIME_W-1:0] r_bi;
    logic [TIME_W-1:0] n_bi;

    logic              r_out_vld;
    logic              n_out_vld;
    logic [TIME_W-1:0] r_out_elapsed;
    logic              r_out_expired;
    logic              r_out_running;

    logic              step;
    logic [TIME_W-1:0] run;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] elapsed_pre;
    logic [TIME_W-1:0] elapsed;
    logic              fire;
    t_op               op;

    assign op          = t_op'(i_item.operation);
    assign o_ready     = !r_out_vld || !i_out_stall;
    assign step        = i_valid && o_ready;

    // start, stop and check all leave elapsed time unchanged
    assign run         = r_active ? (i_item.now_ms - r_start) : '0;
    assign interval    = r_bi + run;
    assign elapsed_pre = r_bt + run + (i_cfg.periodic_mode ? r_bi : '0);
    assign elapsed     = (op == OP_RESET) ? '0 : elapsed_pre;

    always_comb begin
        fire = 1'b0;
        if (op == OP_CHECK && i_cfg.period_ms != '0) begin
            fire = i_cfg.periodic_mode ? (interval >= i_cfg.period_ms)
                                       : (elapsed_pre >= i_cfg.period_ms);
        end
    end

    always_comb begin
        n_active = r_active;
        n_start  = r_start;
        n_bt     = r_bt;
        n_bi     = r_bi;
        if (step) begin
            unique case (op)
                OP_START: begin
                    if (!r_active) begin
                        n_active = 1'b1;
                        n_start  = i_item.now_ms;
                    end
                end
                OP_STOP: begin
                    if (r_active) begin
                        n_active = 1'b0;
                        if (i_cfg.periodic_mode) begin
                            n_bi = r_bi + run;
                        end else begin
                            n_bt = r_bt + run;
                        end
                    end
                end
                OP_RESET: begin
                    n_active = 1'b0;
                    n_start  = '0;
                    n_bt     = '0;
                    n_bi     = '0;
                end
                OP_CHECK: begin
                    if (fire && i_cfg.periodic_mode) begin
                        n_bt = r_bt + i_cfg.period_ms;
                        if (r_active) begin
                            // carry the remainder into the run start
                            n_bi    = '0;
                            n_start = r_start + i_cfg.period_ms - r_bi;
                        end else begin
                            n_bi = r_bi - i_cfg.period_ms;
                        end
                    end
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    assign n_out_vld = step || (r_out_vld && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_start   <= '0;
            r_bt      <= '0;
            r_bi      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_start   <= n_start;
            r_bt      <= n_bt;
            r_bi      <= n_bi;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_elapsed <= elapsed;
            r_out_expired <= fire;
            r_out_running <= n_active;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_out_elapsed_ms = r_out_elapsed;
    assign o_out_expired    = r_out_expired;
    assign o_out_running    = r_out_running;

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && op == OP_RESET |=> r_out_elapsed == '0 && !r_active && r_bt == '0)
        else $error("reset command left state behind");

    a_expired_only_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && op != OP_CHECK |=> !r_out_expired)
        else $error("expiry flagged outside a check");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && op == OP_START |=> r_active && r_out_running)
        else $error("start did not leave timer running");

    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && op == OP_STOP |=> !r_active && !r_out_running)
        else $error("stop did not halt timer");

endmodule

@@ rtl/stopwatch_interval_timer.sv @@
// Top level of the pausable stopwatch / interval timer.
// One command beat is accepted every cycle while the result side does not stall; its result passes
// through the input register, then the single-pass state update into the result register. A stall on
// the result side holds the result register and backs up through the input register.
// Configuration writes are always ready and take effect on the following cycle.
module stopwatch_interval_timer
    import swit_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_in_operation,
    input  logic [TIME_W-1:0] i_in_now_ms,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [TIME_W-1:0] o_out_elapsed_ms,
    output logic              o_out_expired,
    output logic              o_out_running,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [0:0]        i_cfg_index,
    input  logic [TIME_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_item in_item;
    t_item core_item;
    logic  core_valid;
    logic  core_ready;

    assign in_item.operation = i_in_operation;
    assign in_item.now_ms    = i_in_now_ms;

    swit_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    swit_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .o_valid (core_valid),
        .i_ready (core_ready),
        .o_item  (core_item)
    );

    swit_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (core_valid),
        .o_ready          (core_ready),
        .i_item           (core_item),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_elapsed_ms (o_out_elapsed_ms),
        .o_out_expired    (o_out_expired),
        .o_out_running    (o_out_running)
    );

endmodule
